// ----- hdl/alu8_pkg.sv -----
`default_nettype none

package alu8_pkg;

	localparam int unsigned W = 8;
	localparam int unsigned PW = 2 * W;
	localparam int unsigned N_CELLS = W;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	// everything one transaction carries down the cell chain
	typedef struct packed {
		op_t            op;
		logic           sa;
		logic           sb;
		logic [W-1:0]   sum;
		logic           add_ovf;
		logic [W-1:0]   dvd;
		logic [W-1:0]   dsr;
		logic [W-1:0]   rem;
		logic [W-1:0]   quo;
		logic [PW-1:0]  mcand;
		logic [W-1:0]   mplier;
		logic [PW-1:0]  acc;
	} cell_t;

endpackage

`default_nettype wire

// ----- hdl/alu8_cell.sv -----
`default_nettype none

module alu8_cell (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            up_valid,
	output logic           up_ready,
	input  alu8_pkg::cell_t up_data,
	output logic           dn_valid,
	input  wire            dn_ready,
	output alu8_pkg::cell_t dn_data
);
	import alu8_pkg::*;

	cell_t        nxt;
	logic [W-1:0] shifted;
	logic         valid_q;
	cell_t        data_q;

	// one restoring division step and one shift-add multiply step
	always_comb begin
		nxt = up_data;
		shifted = {up_data.rem[W-2:0], up_data.dvd[W-1]};
		nxt.dvd = {up_data.dvd[W-2:0], 1'b0};
		if (shifted >= up_data.dsr) begin
			nxt.rem = shifted - up_data.dsr;
			nxt.quo = {up_data.quo[W-2:0], 1'b1};
		end else begin
			nxt.rem = shifted;
			nxt.quo = {up_data.quo[W-2:0], 1'b0};
		end
		if (up_data.mplier[0]) begin
			nxt.acc = up_data.acc + up_data.mcand;
		end
		nxt.mcand = {up_data.mcand[PW-2:0], 1'b0};
		nxt.mplier = {1'b0, up_data.mplier[W-1:1]};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule

`default_nettype wire

// ----- hdl/alu8_out.sv -----
`default_nettype none

module alu8_out (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            up_valid,
	output logic           up_ready,
	input  alu8_pkg::cell_t up_data,
	output logic           out_valid,
	input  wire            out_ready,
	output logic [7:0]     result_a,
	output logic [7:0]     result_q,
	output logic           overflow_flag
);
	import alu8_pkg::*;

	logic [PW-1:0] prod;
	logic [W-1:0]  quo_s;
	logic [W-1:0]  rem_s;
	logic          p_neg;
	logic          p_pos;
	logic          q_neg;
	logic          q_pos;
	logic [W-1:0]  ra_n;
	logic [W-1:0]  rq_n;
	logic          ovf_n;
	logic          out_valid_q;
	logic [W-1:0]  result_a_q;
	logic [W-1:0]  result_q_q;
	logic          overflow_q;

	always_comb begin
		prod = (up_data.sa != up_data.sb) ? (~up_data.acc + 1'b1) : up_data.acc;
		quo_s = (up_data.sa != up_data.sb) ? (~up_data.quo + 1'b1) : up_data.quo;
		rem_s = up_data.sa ? (~up_data.rem + 1'b1) : up_data.rem;
		p_neg = prod[PW-1];
		p_pos = (prod != '0) && !p_neg;
		q_neg = quo_s[W-1];
		q_pos = (quo_s != '0) && !q_neg;
		case (up_data.op)
			OP_ADD, OP_SUB: begin
				ra_n = up_data.sum;
				rq_n = '0;
				ovf_n = up_data.add_ovf;
			end
			OP_MUL: begin
				ra_n = prod[PW-1:W];
				rq_n = prod[W-1:0];
				ovf_n = ((up_data.sa == up_data.sb) && p_neg)
					|| ((up_data.sa != up_data.sb) && p_pos);
			end
			OP_DIV: begin
				if (up_data.dsr == '0) begin
					ra_n = '0;
					rq_n = '0;
					ovf_n = 1'b1;
				end else begin
					ra_n = rem_s;
					rq_n = quo_s;
					ovf_n = ((up_data.sa == up_data.sb) && q_neg)
						|| ((up_data.sa != up_data.sb) && q_pos);
				end
			end
			default: begin
				ra_n = '0;
				rq_n = '0;
				ovf_n = 1'b0;
			end
		endcase
	end

	assign up_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (up_ready) begin
			out_valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			result_a_q <= ra_n;
			result_q_q <= rq_n;
			overflow_q <= ovf_n;
		end
	end

	assign out_valid = out_valid_q;
	assign result_a = result_a_q;
	assign result_q = result_q_q;
	assign overflow_flag = overflow_q;

endmodule

`default_nettype wire

// ----- hdl/signed_8bit_alu_add_sub_mul_div.sv -----
// signed 8-bit alu: add, subtract, multiply, restoring divide
//
// input channel: in_valid / in_ready with operation, operand_a, operand_b.
// output channel: out_valid / out_ready with result_a, result_q, overflow_flag.
// every accepted transaction gives exactly one result, in order.
//
// the datapath is a row of eight cells, each producing one quotient bit and one
// partial product of the multiply, then the output register that forms the
// signed result and the flag; the first cell loads on the accepting edge.
// throughput is one transaction per cycle while the receiver does not stall;
// every stage of the cell row holds one transaction and hands it on each cycle
// that the stage below it is ready.
//
// when the receiver stalls, the output register holds its result and ready
// travels back through the row, so empty stages keep filling; in_ready drops
// only once every stage holds a transaction.
// reset clears all stage valid bits; the block is empty and ready afterwards.
`default_nettype none

module signed_8bit_alu_add_sub_mul_div (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  operation,
	input  wire [7:0]  operand_a,
	input  wire [7:0]  operand_b,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] result_a,
	output logic [7:0] result_q,
	output logic       overflow_flag
);
	import alu8_pkg::*;

	cell_t        data [0:N_CELLS];
	logic         valid [0:N_CELLS];
	logic         ready [0:N_CELLS];
	logic [W-1:0] neg_b;
	logic [W-1:0] addend;
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;

	always_comb begin
		neg_b = ~operand_b + 1'b1;
		addend = (op_t'(operation) == OP_SUB) ? neg_b : operand_b;
		a_mag = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
		b_mag = operand_b[W-1] ? neg_b : operand_b;

		data[0].op = op_t'(operation);
		data[0].sa = operand_a[W-1];
		data[0].sb = operand_b[W-1];
		data[0].sum = operand_a + addend;
		data[0].add_ovf = (operand_a[W-1] == addend[W-1])
			&& (data[0].sum[W-1] != operand_a[W-1]);
		data[0].dvd = a_mag;
		data[0].dsr = b_mag;
		data[0].rem = '0;
		data[0].quo = '0;
		data[0].mcand = {{W{1'b0}}, a_mag};
		data[0].mplier = b_mag;
		data[0].acc = '0;
	end

	assign valid[0] = in_valid;
	assign in_ready = ready[0];

	for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
		alu8_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid[k]),
			.up_ready (ready[k]),
			.up_data  (data[k]),
			.dn_valid (valid[k+1]),
			.dn_ready (ready[k+1]),
			.dn_data  (data[k+1])
		);
	end

	alu8_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (valid[N_CELLS]),
		.up_ready      (ready[N_CELLS]),
		.up_data       (data[N_CELLS]),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_a      (result_a),
		.result_q      (result_q),
		.overflow_flag (overflow_flag)
	);

	// an accepted transaction lands in the first cell
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid[1])
		else $error("accepted transaction did not enter the cell row");

	// a stalled result must hold back the last cell
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !ready[N_CELLS])
		else $error("last cell released while output is stalled");

	// restoring division keeps the partial remainder below the divisor
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid[N_CELLS] && data[N_CELLS].op == OP_DIV && data[N_CELLS].dsr != '0
		|-> data[N_CELLS].rem < data[N_CELLS].dsr)
		else $error("division remainder not below divisor");

	// magnitude product never exceeds 128 * 128
	a_prod: assert property (@(posedge clk) disable iff (!arst_n)
		valid[N_CELLS] && data[N_CELLS].op == OP_MUL
		|-> data[N_CELLS].acc <= 16'd16384)
		else $error("magnitude product out of range");

endmodule

`default_nettype wire
